>>> src/tet_pkg.sv
// shared types, codes and sizes for the timeout event table
package tet_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_POP    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    // scan filters
    localparam logic [1:0] SCAN_USED = 2'd0;
    localparam logic [1:0] SCAN_ID   = 2'd1;
    localparam logic [1:0] SCAN_FIRE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] event_id;
        logic [31:0] owner_handle;
        logic [31:0] time_value;
        logic        skip_earliest;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] fired_id;
        logic [31:0] fired_owner;
        logic        last_result;
    } rsp_item_t;

    typedef struct packed {
        logic       load_req;
        logic       scan_start;
        logic       scan_step;
        logic [1:0] scan_mode;
        logic       adv_step;
        logic       add_write;
        logic       clear_best;
        logic       set_except;
        logic       clear_except;
        logic       elapsed_from_best;
        logic       emit;
        logic [1:0] emit_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       skip;
        logic       scan_last;
        logic       best_found;
        logic       free_avail;
        logic       out_free;
    } dp_status_t;

endpackage

>>> src/tet_dp.sv
// datapath: slot storage, scan and advance logic, result register
module tet_dp
    import tet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_item_t  req,
    input  dp_cmd_t    cmd,
    output dp_status_t st,
    input  logic       rsp_ready,
    output logic       rsp_valid,
    output rsp_item_t  rsp
);

    // slot storage
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [TABLE_SLOTS-1:0] fire_reg;
    logic [15:0]            id_reg    [TABLE_SLOTS];
    logic [31:0]            owner_reg [TABLE_SLOTS];
    logic [31:0]            rem_reg   [TABLE_SLOTS];

    // request and scan registers
    logic [1:0]        type_reg;
    logic [15:0]       req_id_reg;
    logic [31:0]       req_owner_reg;
    logic              skip_reg;
    logic [31:0]       elapsed_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] best_reg;
    logic [31:0]       best_rem_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] except_reg;
    logic              except_valid_reg;

    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;

    logic [SLOT_W-1:0] free_idx;
    logic              free_avail;
    logic [SLOT_W-1:0] rd_addr;
    logic [15:0]       rd_id;
    logic [31:0]       rd_owner;
    logic [31:0]       rd_rem;
    logic              pass;
    logic              take;
    logic              adv_hit;
    logic              out_free;
    logic              emit_fired;

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_avail = 1'b0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = SLOT_W'(i);
                free_avail = 1'b1;
            end
        end
    end

    assign emit_fired = cmd.emit && (cmd.emit_kind == KIND_FIRED);
    assign rd_addr    = emit_fired ? best_reg : idx_reg;
    assign rd_id      = id_reg[rd_addr];
    assign rd_owner   = owner_reg[rd_addr];
    assign rd_rem     = rem_reg[rd_addr];

    always_comb
    begin
        unique case (cmd.scan_mode)
            SCAN_USED: pass = used_reg[idx_reg];
            SCAN_ID:   pass = used_reg[idx_reg] && (rd_id == req_id_reg);
            SCAN_FIRE: pass = fire_reg[idx_reg];
            default:   pass = 1'b0;
        endcase
    end

    // strict less keeps ties on the lower slot
    assign take     = pass && (!best_found_reg || (rd_rem < best_rem_reg));
    assign adv_hit  = used_reg[idx_reg] && !(except_valid_reg && (except_reg == idx_reg));
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            fire_reg <= '0;
        end
        else
        begin
            if (cmd.add_write && free_avail)
            begin
                used_reg[free_idx] <= 1'b1;
            end
            if (cmd.clear_best && best_found_reg)
            begin
                used_reg[best_reg] <= 1'b0;
                fire_reg[best_reg] <= 1'b0;
            end
            if (cmd.adv_step && adv_hit && (elapsed_reg >= rd_rem))
            begin
                fire_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_write && free_avail)
        begin
            id_reg[free_idx]    <= req_id_reg;
            owner_reg[free_idx] <= req_owner_reg;
            rem_reg[free_idx]   <= elapsed_reg;
        end
        if (cmd.adv_step && adv_hit && (elapsed_reg < rd_rem))
        begin
            rem_reg[idx_reg] <= rd_rem - elapsed_reg;
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_id_reg    <= req.event_id;
            req_owner_reg <= req.owner_handle;
            skip_reg      <= req.skip_earliest;
        end
        if (cmd.load_req)
        begin
            elapsed_reg <= req.time_value;
        end
        else if (cmd.elapsed_from_best)
        begin
            elapsed_reg <= best_rem_reg;
        end
        if (cmd.set_except)
        begin
            except_reg <= best_reg;
        end
        if (cmd.scan_step && take)
        begin
            best_reg     <= idx_reg;
            best_rem_reg <= rd_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg         <= REQ_ADD;
            idx_reg          <= '0;
            best_found_reg   <= 1'b0;
            except_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                type_reg <= req.req_type;
            end
            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step || cmd.adv_step)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.scan_step && take)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.clear_except)
            begin
                except_valid_reg <= 1'b0;
            end
            else if (cmd.set_except)
            begin
                except_valid_reg <= best_found_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.result_kind <= cmd.emit_kind;
            if (emit_fired)
            begin
                rsp_reg.fired_id    <= rd_id;
                rsp_reg.fired_owner <= rd_owner;
                rsp_reg.last_result <= 1'b0;
            end
            else
            begin
                rsp_reg.fired_id    <= '0;
                rsp_reg.fired_owner <= '0;
                rsp_reg.last_result <= 1'b1;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign st.req_type   = type_reg;
    assign st.skip       = skip_reg;
    assign st.scan_last  = (idx_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign st.best_found = best_found_reg;
    assign st.free_avail = free_avail;
    assign st.out_free   = out_free;

    // a pending fire mark always sits on a live slot
    a_fire_on_used: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_reg & ~used_reg) == '0)
        else $error("fire mark on a free slot");

    // a fired result comes from a found, live slot
    a_fired_live: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fired |-> (best_found_reg && used_reg[best_reg]))
        else $error("fired result from an empty slot");

    // the final result of a request leaves no fire mark behind
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.emit_kind == KIND_DONE)) |-> (fire_reg == '0))
        else $error("request finished with expired entries left");

    // never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result register overrun");

endmodule

>>> src/tet_ctrl.sv
// controller: sequences add, cancel, tick and pop over the datapath
module tet_ctrl
    import tet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_ADD      = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_SCAN_END = 4'd4;
    localparam logic [3:0] S_ADV      = 4'd5;
    localparam logic [3:0] S_FSCAN    = 4'd6;
    localparam logic [3:0] S_FEMIT    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.scan_mode = (st.req_type == REQ_CANCEL) ? SCAN_ID : SCAN_USED;
        cmd.emit_kind = KIND_DONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.scan_start   = 1'b1;
                cmd.clear_except = 1'b1;
                unique case (st.req_type)
                    REQ_ADD:    state_next = S_ADD;
                    REQ_CANCEL: state_next = S_SCAN;
                    REQ_TICK:   state_next = st.skip ? S_SCAN : S_ADV;
                    REQ_POP:    state_next = S_SCAN;
                    default:    state_next = S_DONE;
                endcase
            end
            S_ADD:
            begin
                if (st.out_free)
                begin
                    cmd.add_write = st.free_avail;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = st.free_avail ? KIND_DONE : KIND_FULL;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                unique case (st.req_type)
                    REQ_CANCEL:
                    begin
                        cmd.clear_best = 1'b1;
                        state_next     = S_DONE;
                    end
                    REQ_TICK:
                    begin
                        cmd.set_except = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = S_ADV;
                    end
                    REQ_POP:
                    begin
                        if (st.best_found)
                        begin
                            cmd.clear_best        = 1'b1;
                            cmd.elapsed_from_best = 1'b1;
                            cmd.scan_start        = 1'b1;
                            state_next            = S_ADV;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_ADV:
            begin
                cmd.adv_step = 1'b1;
                if (st.scan_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                cmd.scan_mode = SCAN_FIRE;
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_FEMIT;
                end
            end
            S_FEMIT:
            begin
                if (!st.best_found)
                begin
                    state_next = S_DONE;
                end
                else if (st.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_FIRED;
                    cmd.clear_best = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_FSCAN;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/timeout_event_table.sv
// top level of the timeout event table
//
//   channel | signals                    | moves
//   --------+----------------------------+------------------------------------
//   req     | req_valid, req_ready, req  | one request item (add/cancel/tick/pop)
//   rsp     | rsp_valid, rsp_ready, rsp  | one result item, last_result on final
//
// one request is worked at a time; req_ready is high only while the controller idles
// add: dispatch, then write and result; cancel: a scan of all slots (one slot compared per cycle)
// tick: an advance pass over all slots, then one search over all slots for each next due
//   entry (one per fired entry plus the one that finds none), then the done result
// a skip tick or a pop first scans all slots for the head
// the final result waits in the result register while the next request is taken
// a stalled rsp channel holds the controller at its next emit; reset empties all slots
module timeout_event_table
    import tet_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    // command and status between controller and datapath
    dp_cmd_t    cmd;
    dp_status_t st;

    // sequencer for the four request kinds
    tet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // slot table, scan compare, advance subtract and result register
    tet_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
